// File: hw/rtl/pbci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbci_pkg
// Types and constants shared by the pitch-bend curve interpolator.
// ----------------------------------------------------------------------------
package pbci_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int DIV_W         = 40;   // dividend and quotient width
  localparam int DVS_W         = 16;   // divisor width

  localparam logic [15:0] STEP_RESET  = 16'd60;
  localparam logic [13:0] BEND_CENTRE = 14'd8192;
  localparam logic [12:0] BEND_SPAN   = 13'd8191;
  localparam logic [10:0] BEND_LIMIT  = 11'd1200;
  localparam logic [7:0]  STATUS_BEND = 8'hE0;

  // ceil(BEND_SPAN * 2^BEND_SHIFT / BEND_LIMIT); exact floor for |cents| <= 1200
  localparam int          BEND_SHIFT  = 22;
  localparam logic [24:0] BEND_RECIP  = 25'd28629621;

  localparam logic [1:0] OP_FIRST = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         channel;
    logic [31:0]        tick;
    logic [23:0]        offset;
    logic signed [15:0] cents;
  } in_item_t;

  typedef struct packed {
    logic [31:0] at_tick;
    logic [7:0]  status_byte;
    logic [6:0]  data_low;
    logic [6:0]  data_high;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: hw/rtl/pbci_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbci_div
// Shared restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module pbci_div
  import pbci_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DIV_W-1:0] quo_r;

  logic [DVS_W:0]   sh;
  logic             fit;

  // trial subtract of the shifted remainder
  assign sh  = {rem_r, quo_r[DIV_W-1]};
  assign fit = sh >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fit ? DVS_W'(sh - {1'b0, dvs_r}) : sh[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fit};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (cnt_r != CNT_W'(1)) |-> !req.start)
    else $error("divider restarted while busy");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0) && (cnt_r <= CNT_W'(DIV_W)))
    else $error("divider count out of range");

endmodule

// File: hw/rtl/pitch_bend_curve_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_bend_curve_interpolator
// Turns bend points of a note into timed pitch-bend items.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one bend item (op, channel, tick, offset, cents).
//   out_valid/out_ready carry pitch-bend items; last marks the final item
//   caused by one input item. cfg_we/cfg_data write step_ticks.
//   Op 0 and op 2 give one item, op 1 gives one item per line step, up to
//   MAX_STEPS items; op 3 gives none.
// Timing:
//   Tick and cents divisions run through one shared divider; each is a start,
//   one shift per quotient bit (DIV_W = 40) and a done. The bend value comes
//   from a reciprocal multiply registered in S_BEND. Op 0 and the zero-span
//   case pass S_SETUP, S_BEND and S_EMIT to out_valid, op 2 skips S_BEND. An
//   interpolated op 1 runs the step count division once, then tick and
//   cents divisions for each item. in_ready is high only while no item is
//   in work and returns the cycle after the final item loads.
// Reset and stall:
//   rst_n clears the state (note start, stored point) and sets step_ticks
//   to 60. The output register holds a finished item while out_ready is low;
//   the sequencer keeps computing the next one and waits only to load it.
// ----------------------------------------------------------------------------
module pitch_bend_curve_interpolator
  import pbci_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_data
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_DSPAN  = 4'd2;
  localparam logic [3:0] S_DSPANW = 4'd3;
  localparam logic [3:0] S_DTICK  = 4'd4;
  localparam logic [3:0] S_DTICKW = 4'd5;
  localparam logic [3:0] S_DCENT  = 4'd6;
  localparam logic [3:0] S_DCENTW = 4'd7;
  localparam logic [3:0] S_BEND   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] step_r;

  logic [31:0] note_start_r, seg_tick_r, base_tick_r;
  logic signed [15:0] seg_cents_r, base_cents_r;
  in_item_t    item_r;

  logic [31:0] span_r;
  logic signed [16:0] diff_r;
  logic [STEP_W-1:0] steps_r, k_r;
  logic        interp_r;

  logic [31:0] msg_tick_r;
  logic signed [16:0] cur_c_r;
  logic [13:0] value_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [31:0] to_tick;
  logic [31:0] earliest;
  logic signed [16:0] clamp_c;
  logic [10:0] clamp_mag;
  logic [35:0] bend_prod;
  logic [15:0] diff_mag;
  logic        load;
  logic        more;

  pbci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign to_tick  = sat_add(note_start_r, {8'd0, item_r.offset});
  assign earliest = sat_add(note_start_r, 32'd1);
  assign diff_mag = diff_r[16] ? 16'(-diff_r) : diff_r[15:0];

  // clamp cents to the bend range
  always_comb begin
    if (cur_c_r > 17'sd1200)       clamp_c = 17'sd1200;
    else if (cur_c_r < -17'sd1200) clamp_c = -17'sd1200;
    else                           clamp_c = cur_c_r;
    clamp_mag = clamp_c[16] ? 11'(-clamp_c) : clamp_c[10:0];
  end

  // scale the clamped magnitude by 8191/1200 through a reciprocal multiply
  assign bend_prod = 36'(clamp_mag) * 36'(BEND_RECIP);

  // divider requests
  always_comb begin
    dreq = '0;
    case (state_r)
      S_DSPAN: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(span_r);
        dreq.divisor  = (step_r == 16'd0) ? 16'd1 : step_r;
      end
      S_DTICK: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(span_r) * DIV_W'(k_r);
        dreq.divisor  = DVS_W'(steps_r);
      end
      S_DCENT: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(diff_mag) * DIV_W'(k_r);
        dreq.divisor  = DVS_W'(steps_r);
      end
      default: dreq = '0;
    endcase
  end

  assign load = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign more = interp_r && (k_r != steps_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SETUP;
      S_SETUP: begin
        case (item_r.op)
          OP_FIRST: state_nxt = S_BEND;
          OP_NEXT:  state_nxt = (to_tick > seg_tick_r) ? S_DSPAN : S_BEND;
          OP_END:   state_nxt = S_EMIT;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_DSPAN:  state_nxt = S_DSPANW;
      S_DSPANW: if (drsp.done) state_nxt = S_DTICK;
      S_DTICK:  state_nxt = S_DTICKW;
      S_DTICKW: if (drsp.done) state_nxt = S_DCENT;
      S_DCENT:  state_nxt = S_DCENTW;
      S_DCENTW: if (drsp.done) state_nxt = S_BEND;
      S_BEND:   state_nxt = S_EMIT;
      S_EMIT:   if (load) state_nxt = more ? S_DTICK : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control and stored bend state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= STEP_RESET;
      note_start_r <= '0;
      seg_tick_r   <= '0;
      seg_cents_r  <= '0;
      out_valid_r  <= 1'b0;
      interp_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) step_r <= cfg_data;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == S_SETUP) begin
        interp_r <= 1'b0;
        if (item_r.op == OP_FIRST) begin
          note_start_r <= item_r.tick;
          seg_tick_r   <= sat_add(item_r.tick, {8'd0, item_r.offset});
          seg_cents_r  <= item_r.cents;
        end else if (item_r.op == OP_NEXT) begin
          seg_tick_r  <= to_tick;
          seg_cents_r <= item_r.cents;
          interp_r    <= to_tick > seg_tick_r;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    case (state_r)
      S_SETUP: begin
        base_tick_r  <= seg_tick_r;
        base_cents_r <= seg_cents_r;
        span_r       <= to_tick - seg_tick_r;
        diff_r       <= 17'(item_r.cents) - 17'(seg_cents_r);
        cur_c_r      <= 17'(item_r.cents);
        value_r      <= BEND_CENTRE;
        case (item_r.op)
          OP_FIRST: msg_tick_r <= item_r.tick;
          OP_NEXT:  msg_tick_r <= to_tick;
          default:  msg_tick_r <= (item_r.tick > earliest) ? item_r.tick : earliest;
        endcase
      end
      S_DSPANW: if (drsp.done) begin
        k_r <= STEP_W'(1);
        if (drsp.quotient == '0)                     steps_r <= STEP_W'(1);
        else if (drsp.quotient > DIV_W'(MAX_STEPS)) steps_r <= STEP_W'(MAX_STEPS);
        else                                         steps_r <= drsp.quotient[STEP_W-1:0];
      end
      S_DTICKW: if (drsp.done) msg_tick_r <= base_tick_r + drsp.quotient[31:0];
      S_DCENTW: if (drsp.done) begin
        cur_c_r <= diff_r[16] ? 17'(base_cents_r) - drsp.quotient[16:0]
                              : 17'(base_cents_r) + drsp.quotient[16:0];
      end
      S_BEND: begin
        value_r <= clamp_c[16] ? BEND_CENTRE - bend_prod[BEND_SHIFT +: 14]
                               : BEND_CENTRE + bend_prod[BEND_SHIFT +: 14];
      end
      S_EMIT: if (load && more) k_r <= k_r + STEP_W'(1);
      default: ;
    endcase
    if (load) begin
      out_data_r.at_tick     <= msg_tick_r;
      out_data_r.status_byte <= STATUS_BEND | {4'd0, item_r.channel};
      out_data_r.data_low    <= value_r[6:0];
      out_data_r.data_high   <= value_r[13:7];
      out_data_r.last        <= !more;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_step_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DTICK) |-> (steps_r != '0) && (k_r != '0) && (k_r <= steps_r))
    else $error("interpolation step out of range");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !out_valid_r || out_ready)
    else $error("output item overwritten before taken");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load && !more |=> (state_r == S_IDLE) && out_valid_r && out_data_r.last)
    else $error("final item did not return to idle");

endmodule
